FILE: rtl/core/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types, codes and widths of the Bernoulli log-likelihood block.
// ----------------------------------------------------------------------------
`default_nettype none

package blm_pkg;

    localparam int MAX_VARS   = 1024;
    localparam int COUNT_BITS = 20;

    localparam int VAR_AW   = $clog2(MAX_VARS);
    localparam int LP_AW    = VAR_AW + 1;
    localparam int IDX_W    = 10;
    localparam int NV_W     = 11;
    localparam int ALPHA_W  = 16;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int LL_W     = 33;
    localparam int SUM_W    = 34;
    localparam int LP_W     = 23;
    localparam int CFG_W    = 16;
    localparam int NUM_W    = COUNT_BITS + 9;
    localparam int LOG_FRAC = 24;
    localparam int EXP_W    = 5;
    localparam int LOG_W    = EXP_W + LOG_FRAC;
    localparam int MANT_W   = 32;
    localparam int PROD_W   = LOG_W + 32;
    localparam int ITER_W   = $clog2(LOG_FRAC);

    localparam logic [COUNT_BITS-1:0] COUNT_CAP = '1;
    localparam logic [NV_W-1:0]       POS_MAX   = '1;
    localparam logic [NV_W-1:0]       NV_MAX    = NV_W'(MAX_VARS);
    localparam logic [31:0]           LN2_Q32   = 32'd2977044472;
    localparam logic [LP_W-1:0]       LOG_FLOOR = LP_W'(64 * 65536);

    localparam logic [0:0] REG_NUM_VARS = 1'b0;
    localparam logic [0:0] REG_ALPHA    = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_BEGIN_FIT  = 3'd0,
        FN_FIT_ONE    = 3'd1,
        FN_ROW_END    = 3'd2,
        FN_FINISH_FIT = 3'd3,
        FN_EVAL_BIT   = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_EVAL_OK    = 3'd0,
        ST_FIT_DONE   = 3'd1,
        ST_NOT_FITTED = 3'd2,
        ST_LEN_ERR    = 3'd3,
        ST_BAD_INDEX  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FIT_WR,
        S_EV_ADD,
        S_FIN_DS,
        S_FIN_DW,
        S_FIN_RD,
        S_FIN_N,
        S_FIN_LS,
        S_FIN_LW,
        S_FIN_MUL,
        S_FIN_WR,
        S_FIN_END,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQUARE
    } lg_state_t;

    typedef struct packed {
        logic    ready;
        logic    clr_wr;
        logic    sweep_rst;
        logic    sweep_inc;
        logic    cnt_wr_fit;
        logic    cnt_rd_fin;
        logic    row_inc;
        logic    model_clr;
        logic    set_ready;
        logic    ev_add;
        logic    den_latch;
        logic    log_start;
        logic    log_den;
        logic    lp_bit;
        logic    logden_latch;
        logic    n_latch;
        logic    mag_latch;
        logic    prod_latch;
        logic    lp_wr;
        logic    res_load;
        status_t res_code;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic  in_valid;
        func_t func;
        logic  last;
        logic  idx_bad;
        logic  sweep_last;
        logic  fin_last;
        logic  nv_zero;
        logic  log_done;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/blm_log2.sv
// ----------------------------------------------------------------------------
// blm_log2
// Iterative log2 in Q.24: normalising shift, then one squaring per bit.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_log2 (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [blm_pkg::NUM_W-1:0]  val,
    output logic                            done,
    output logic [blm_pkg::LOG_W-1:0]       res
);
    import blm_pkg::*;

    lg_state_t             state_reg, state_next;
    logic [MANT_W-1:0]     m_reg, m_next;
    logic [EXP_W-1:0]      e_reg, e_next;
    logic [LOG_FRAC-1:0]   r_reg, r_next;
    logic [ITER_W-1:0]     i_reg, i_next;
    logic                  done_next;
    logic [2*MANT_W-1:0]   sq;
    logic [MANT_W:0]       sq_t;

    assign sq   = m_reg * m_reg;
    assign sq_t = sq[2*MANT_W-1:MANT_W-1];

    always_comb begin
        state_next = state_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        done_next  = 1'b0;
        case (state_reg)
            LG_IDLE: begin
                if (start) begin
                    m_next     = MANT_W'(val);
                    e_next     = EXP_W'(MANT_W - 1);
                    r_next     = '0;
                    state_next = LG_NORM;
                end
            end
            LG_NORM: begin
                // zero input ends at once, the caller ignores the result
                if (m_reg == '0 || m_reg[MANT_W-1]) begin
                    i_next = ITER_W'(LOG_FRAC - 1);
                    if (m_reg == '0) begin
                        done_next  = 1'b1;
                        state_next = LG_IDLE;
                    end else begin
                        state_next = LG_SQUARE;
                    end
                end else if (m_reg[MANT_W-1 -: 4] == 4'd0) begin
                    m_next = m_reg << 4;
                    e_next = e_reg - EXP_W'(4);
                end else begin
                    m_next = m_reg << 1;
                    e_next = e_reg - EXP_W'(1);
                end
            end
            LG_SQUARE: begin
                if (sq_t[MANT_W]) begin
                    m_next        = sq_t[MANT_W:1];
                    r_next[i_reg] = 1'b1;
                end else begin
                    m_next = sq_t[MANT_W-1:0];
                end
                i_next = i_reg - ITER_W'(1);
                if (i_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = LG_IDLE;
                end
            end
            default: state_next = LG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LG_IDLE;
            done      <= 1'b0;
        end else begin
            state_reg <= state_next;
            done      <= done_next;
        end
        m_reg <= m_next;
        e_reg <= e_next;
        r_reg <= r_next;
        i_reg <= i_next;
    end

    assign res = {e_reg, r_reg};

endmodule

`default_nettype wire

FILE: rtl/core/blm_ctrl.sv
// ----------------------------------------------------------------------------
// blm_ctrl
// Sequencer: clear sweep, fit updates, evaluation and the fit-finish walk.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire blm_pkg::sts_t sts,
    output blm_pkg::cmd_t      cmd
);
    import blm_pkg::*;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cmd          = '0;
        cmd.res_code = ST_EVAL_OK;
        cmd.lp_bit   = phase_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr    = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.ready = 1'b1;
                if (sts.in_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                case (sts.func)
                    FN_BEGIN_FIT: begin
                        cmd.model_clr = 1'b1;
                        cmd.sweep_rst = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    FN_FIT_ONE: begin
                        if (sts.idx_bad) begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = ST_BAD_INDEX;
                            state_next   = S_OUT;
                        end else begin
                            state_next = S_FIT_WR;
                        end
                    end
                    FN_ROW_END:    cmd.row_inc = 1'b1;
                    FN_FINISH_FIT: begin
                        cmd.den_latch = 1'b1;
                        cmd.sweep_rst = 1'b1;
                        state_next    = S_FIN_DS;
                    end
                    FN_EVAL_BIT:   state_next = S_EV_ADD;
                    default:       state_next = S_IDLE;
                endcase
            end
            S_FIT_WR: begin
                cmd.cnt_wr_fit = 1'b1;
                state_next     = S_IDLE;
            end
            S_EV_ADD: begin
                cmd.ev_add = 1'b1;
                state_next = sts.last ? S_OUT : S_IDLE;
            end
            S_FIN_DS: begin
                cmd.log_start = 1'b1;
                cmd.log_den   = 1'b1;
                state_next    = S_FIN_DW;
            end
            S_FIN_DW: begin
                if (sts.log_done) begin
                    cmd.logden_latch = 1'b1;
                    state_next       = sts.nv_zero ? S_FIN_END : S_FIN_RD;
                end
            end
            S_FIN_RD: begin
                cmd.cnt_rd_fin = 1'b1;
                phase_next     = 1'b1;
                state_next     = S_FIN_N;
            end
            S_FIN_N: begin
                cmd.n_latch = 1'b1;
                state_next  = S_FIN_LS;
            end
            S_FIN_LS: begin
                cmd.log_start = 1'b1;
                state_next    = S_FIN_LW;
            end
            S_FIN_LW: begin
                if (sts.log_done) begin
                    cmd.mag_latch = 1'b1;
                    state_next    = S_FIN_MUL;
                end
            end
            S_FIN_MUL: begin
                cmd.prod_latch = 1'b1;
                state_next     = S_FIN_WR;
            end
            S_FIN_WR: begin
                cmd.lp_wr = 1'b1;
                if (phase_reg) begin
                    phase_next = 1'b0;
                    state_next = S_FIN_LS;
                end else if (sts.fin_last) begin
                    state_next = S_FIN_END;
                end else begin
                    cmd.sweep_inc = 1'b1;
                    state_next    = S_FIN_RD;
                end
            end
            S_FIN_END: begin
                cmd.set_ready = 1'b1;
                cmd.res_load  = 1'b1;
                cmd.res_code  = ST_FIT_DONE;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/blm_dp.sv
// ----------------------------------------------------------------------------
// blm_dp
// Datapath: count and log memories, counters, fit arithmetic, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [blm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    input  wire logic [15:0]                   s_tdata,
    input  wire logic                          s_tlast,
    input  wire logic [blm_pkg::FUNC_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [39:0]                        m_tdata,
    output logic [blm_pkg::STATUS_W-1:0]       m_tuser,
    input  wire blm_pkg::cmd_t                 cmd,
    output blm_pkg::sts_t                      sts
);
    import blm_pkg::*;

    // configuration
    logic [NV_W-1:0]    num_vars_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [NV_W-1:0]    nv;

    // captured item
    func_t              func_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               bit_reg;
    logic               last_reg;

    logic [COUNT_BITS-1:0] row_count_reg;
    logic                  model_ready_reg;
    logic [SUM_W-1:0]      row_sum_reg;
    logic [NV_W-1:0]       pos_reg;
    logic [VAR_AW-1:0]     sweep_reg;

    logic [COUNT_BITS-1:0] cnt_mem [MAX_VARS];
    logic [COUNT_BITS-1:0] cnt_rdata_reg;
    logic [VAR_AW-1:0]     cnt_raddr, cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  cnt_we;

    logic [LP_W-1:0]       lp_mem [2*MAX_VARS];
    logic [LP_W-1:0]       lp_rdata_reg;
    logic [LP_W-1:0]       lp_wdata;

    logic [NUM_W-1:0]      den_reg, n1_reg, n1_raw, lg_val;
    logic [LOG_W-1:0]      logden_reg, mag_reg, lg_res;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W:0]       rnd;
    logic [LP_W-1:0]       q, q_sat;
    logic                  lp_zero, lg_done;

    logic                  add_en;
    logic [SUM_W-1:0]      sum_next;
    logic [NV_W-1:0]       pos_next;

    status_t               res_status_reg;
    logic [LL_W-1:0]       res_ll_reg;
    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [LL_W-1:0]       m_ll_reg;

    assign nv = (num_vars_reg > NV_MAX) ? NV_MAX : num_vars_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vars_reg <= NV_W'(1);
            alpha_reg    <= ALPHA_W'(256);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NUM_VARS: num_vars_reg <= cfg_data[NV_W-1:0];
                REG_ALPHA:    alpha_reg    <= cfg_data[ALPHA_W-1:0];
                default:      num_vars_reg <= num_vars_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && cmd.ready) begin
            func_reg <= func_t'(s_tuser);
            idx_reg  <= s_tdata[IDX_W-1:0];
            bit_reg  <= s_tdata[IDX_W];
            last_reg <= s_tlast;
        end
    end

    // one-count memory
    assign cnt_raddr = cmd.cnt_rd_fin ? sweep_reg : idx_reg[VAR_AW-1:0];
    assign cnt_waddr = cmd.clr_wr ? sweep_reg : idx_reg[VAR_AW-1:0];
    assign cnt_we    = cmd.clr_wr || cmd.cnt_wr_fit;
    assign cnt_wdata = cmd.clr_wr ? '0 :
                       (cnt_rdata_reg == COUNT_CAP) ? cnt_rdata_reg
                                                    : cnt_rdata_reg + COUNT_BITS'(1);

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    // log memory, entry 2v+b
    always_ff @(posedge aclk) begin
        if (cmd.lp_wr) begin
            lp_mem[{sweep_reg, cmd.lp_bit}] <= lp_wdata;
        end
        lp_rdata_reg <= lp_mem[{pos_reg[VAR_AW-1:0], bit_reg}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_rst) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_inc) begin
            sweep_reg <= sweep_reg + VAR_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg   <= '0;
            model_ready_reg <= 1'b0;
        end else if (cmd.model_clr) begin
            row_count_reg   <= '0;
            model_ready_reg <= 1'b0;
        end else begin
            if (cmd.row_inc && row_count_reg != COUNT_CAP) begin
                row_count_reg <= row_count_reg + COUNT_BITS'(1);
            end
            if (cmd.set_ready) begin
                model_ready_reg <= 1'b1;
            end
        end
    end

    // evaluation
    assign add_en   = model_ready_reg && (pos_reg < NV_MAX);
    assign sum_next = add_en ? row_sum_reg + {{(SUM_W-LP_W){lp_rdata_reg[LP_W-1]}}, lp_rdata_reg}
                             : row_sum_reg;
    assign pos_next = (pos_reg < POS_MAX) ? pos_reg + NV_W'(1) : pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sum_reg <= '0;
            pos_reg     <= '0;
        end else if (cmd.ev_add) begin
            if (last_reg) begin
                row_sum_reg <= '0;
                pos_reg     <= '0;
            end else begin
                row_sum_reg <= sum_next;
                pos_reg     <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_code;
            res_ll_reg     <= '0;
        end else if (cmd.ev_add) begin
            res_ll_reg <= '0;
            if (!model_ready_reg) begin
                res_status_reg <= ST_NOT_FITTED;
            end else if (pos_next != nv) begin
                res_status_reg <= ST_LEN_ERR;
            end else begin
                res_status_reg <= ST_EVAL_OK;
                res_ll_reg     <= sum_next[LL_W-1:0];
            end
        end
    end

    // fit finish arithmetic
    assign n1_raw = NUM_W'({cnt_rdata_reg, 8'd0}) + NUM_W'(alpha_reg);
    assign lg_val = cmd.log_den ? den_reg : (cmd.lp_bit ? n1_reg : den_reg - n1_reg);

    always_ff @(posedge aclk) begin
        if (cmd.den_latch) begin
            den_reg <= NUM_W'({row_count_reg, 8'd0}) + NUM_W'({alpha_reg, 1'b0});
        end
        if (cmd.n_latch) begin
            n1_reg <= (n1_raw > den_reg) ? den_reg : n1_raw;
        end
        if (cmd.logden_latch) begin
            logden_reg <= lg_res;
        end
        if (cmd.mag_latch) begin
            mag_reg <= logden_reg - lg_res;
        end
        if (cmd.prod_latch) begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(LN2_Q32);
        end
    end

    blm_log2 u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.log_start),
        .val     (lg_val),
        .done    (lg_done),
        .res     (lg_res)
    );

    // round half-up to Q.16, saturate at 64.0, negate
    assign rnd      = {1'b0, prod_reg} + ((PROD_W+1)'(1) << 39);
    assign q        = LP_W'(rnd[PROD_W:40]);
    assign q_sat    = (q > LOG_FLOOR) ? LOG_FLOOR : q;
    assign lp_zero  = (den_reg == '0) || (cmd.lp_bit ? (n1_reg == '0) : (n1_reg == den_reg));
    assign lp_wdata = lp_zero ? -LOG_FLOOR : -q_sat;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_ll_reg     <= res_ll_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_ll_reg};
    assign m_tuser  = m_status_reg;

    assign sts.in_valid   = s_tvalid;
    assign sts.func       = func_reg;
    assign sts.last       = last_reg;
    assign sts.idx_bad    = ({1'b0, idx_reg} >= nv);
    assign sts.sweep_last = (sweep_reg == VAR_AW'(MAX_VARS - 1));
    assign sts.fin_last   = ((NV_W'(sweep_reg) + NV_W'(1)) == nv);
    assign sts.nv_zero    = (nv == '0);
    assign sts.log_done   = lg_done;
    assign sts.out_free   = !m_valid_reg || m_tready;

endmodule

`default_nettype wire

FILE: rtl/core/bernoulli_loglik_model_top.sv
// ----------------------------------------------------------------------------
// bernoulli_loglik_model_top
// Independent Bernoulli model: fit counting, log table build and row scoring.
// ----------------------------------------------------------------------------
// items pass S_EXEC, then fit_one S_FIT_WR and eval_bit S_EV_ADD; fit_row_end
//   ends in S_EXEC; a bad index item or the last eval_bit of a row goes to S_OUT
// finish_fit: the denominator log, then two logs per variable, all on the one
//   shared log2 unit (normalising shift plus 24 squaring steps)
// one item at a time; a result beat waits in the output register meanwhile
// reset and begin_fit sweep all 1024 count memory entries, with no item accepted
// ----------------------------------------------------------------------------
`default_nettype none

module bernoulli_loglik_model_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [0:0]                 cfg_index,
    input  wire logic [blm_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [15:0]                s_tdata,   // var_index, bit_value
    input  wire logic                       s_tlast,
    input  wire logic [blm_pkg::FUNC_W-1:0] s_tuser,   // func
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [39:0]                     m_tdata,   // log_likelihood
    output logic [blm_pkg::STATUS_W-1:0]    m_tuser    // status
);
    import blm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    blm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    blm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign s_tready = cmd.ready;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous one in flight");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_EVAL_OK) |-> (m_tdata == '0))
        else $error("non-eval result carries a likelihood");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// bernoulli_loglik_model_top testbench
// Drives fit and eval streams through the block. An in-bench model of the
// counts, the log table and the row scoring predicts every result beat, and
// each beat is checked field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import blm_pkg::*;

typedef struct {
    status_t          status;
    logic [LL_W-1:0]  loglik;
} loglik_beat_t;

class loglik_scoreboard;
    int unsigned      nv_reg;
    int unsigned      alpha;
    longint unsigned  ones[MAX_VARS];
    int               lp_table[2*MAX_VARS];
    longint unsigned  rows;
    bit               fitted;
    longint           acc;
    int unsigned      pos;
    loglik_beat_t     pending_q[$];
    int unsigned      mismatches;

    function new();
        nv_reg = 1;
        alpha = 256;
        foreach (ones[i]) ones[i] = 0;
        foreach (lp_table[i]) lp_table[i] = 0;
        rows = 0;
        fitted = 0;
        acc = 0;
        pos = 0;
        mismatches = 0;
    endfunction

    function int unsigned eff_vars();
        return (nv_reg > MAX_VARS) ? MAX_VARS : nv_reg;
    endfunction

    // log2 in q.24 by repeated squaring of the normalised mantissa
    function bit [63:0] log2_q24(bit [63:0] v);
        int        e;
        bit [63:0] m;
        bit [63:0] r;
        e = 63;
        while (v[e] == 1'b0) e--;
        m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
        r = 64'(e) << LOG_FRAC;
        for (int i = LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if ((m >> 32) != 0) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function int ln_q16(bit [63:0] n, bit [63:0] d);
        bit [63:0] mag;
        bit [63:0] q;
        if (n == 0) return -(64 * 65536);
        mag = log2_q24(d) - log2_q24(n);
        q = (mag * 64'(LN2_Q32) + (64'd1 << 39)) >> 40;
        if (q > 64 * 65536) q = 64 * 65536;
        return -int'(q);
    endfunction

    function void build_table();
        bit [63:0] den;
        bit [63:0] n1;
        den = rows * 256 + 2 * alpha;
        for (int v = 0; v < eff_vars(); v++) begin
            if (den == 0) begin
                lp_table[2*v] = -(64 * 65536);
                lp_table[2*v+1] = -(64 * 65536);
            end else begin
                n1 = ones[v] * 256 + alpha;
                if (n1 > den) n1 = den;
                lp_table[2*v] = ln_q16(den - n1, den);
                lp_table[2*v+1] = ln_q16(n1, den);
            end
        end
        fitted = 1;
    endfunction

    function void push(status_t st, logic [LL_W-1:0] ll);
        loglik_beat_t b;
        b.status = st;
        b.loglik = ll;
        pending_q.insert(pending_q.size(), b);
    endfunction

    function void note_input(logic [2:0] fn, logic [IDX_W-1:0] idx, logic bv, logic lst);
        case (fn)
            FN_BEGIN_FIT: begin
                foreach (ones[i]) ones[i] = 0;
                rows = 0;
                fitted = 0;
            end
            FN_FIT_ONE: begin
                if (idx >= eff_vars()) push(ST_BAD_INDEX, '0);
                else if (ones[idx] < COUNT_CAP) ones[idx]++;
            end
            FN_ROW_END: begin
                if (rows < COUNT_CAP) rows++;
            end
            FN_FINISH_FIT: begin
                build_table();
                push(ST_FIT_DONE, '0);
            end
            FN_EVAL_BIT: begin
                if (fitted && pos < MAX_VARS) acc += lp_table[2*pos + bv];
                if (pos < POS_MAX) pos++;
                if (lst) begin
                    if (!fitted) push(ST_NOT_FITTED, '0);
                    else if (pos != eff_vars()) push(ST_LEN_ERR, '0);
                    else push(ST_EVAL_OK, LL_W'(acc));
                    acc = 0;
                    pos = 0;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [LL_W-1:0] ll);
        loglik_beat_t b;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: status %0d loglik %0h", st, ll);
            return;
        end
        b = pending_q.pop_front();
        if (st !== b.status || ll !== b.loglik) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: status exp %0d got %0d, loglik exp %0h got %0h",
                         b.status, st, b.loglik, ll);
        end
    endfunction
endclass

module testbench;
    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [0:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // var_index, bit_value
    logic                 s_tlast;
    logic [FUNC_W-1:0]    s_tuser;   // func
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;   // log_likelihood
    logic [STATUS_W-1:0]  m_tuser;   // status

    loglik_scoreboard sb = new();
    int unsigned in_beats = 0;
    int unsigned out_beats = 0;
    int unsigned items_sent = 0;
    int unsigned hold_len = 0;
    bit          no_idle = 0;

    bernoulli_loglik_model_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_input(s_tuser, s_tdata[IDX_W-1:0], s_tdata[IDX_W], s_tlast);
            in_beats <= in_beats + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata[LL_W-1:0]);
            out_beats <= out_beats + 1;
        end
    end

    task automatic send_item(logic [2:0] fn, int unsigned idx, bit bv, bit lst);
        int unsigned gap;
        int unsigned target;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser = fn;
        s_tdata = {5'd0, bv, IDX_W'(idx)};
        s_tlast = lst;
        s_tvalid = 1'b1;
        target = in_beats + 1;
        while (in_beats < target) @(negedge aclk);
        items_sent++;
    endtask

    task automatic idle_sender();
        s_tvalid = 1'b0;
        @(negedge aclk);
    endtask

    // waits out the last beat and the count memory sweep of a begin_fit
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (1100) @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] index, int unsigned value);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = CFG_W'(value);
        @(negedge aclk);
        cfg_we = 1'b0;
        if (index == REG_NUM_VARS) sb.nv_reg = value & 11'h7ff;
        else sb.alpha = value & 16'hffff;
    endtask

    task automatic setup(int unsigned nv, int unsigned alpha_q8);
        drain();
        write_reg(REG_NUM_VARS, nv);
        write_reg(REG_ALPHA, alpha_q8);
    endtask

    task automatic eval_row(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(FN_EVAL_BIT, $urandom_range(0, 1023), $urandom_range(0, 1), i == len - 1);
    endtask

    task automatic noise();
        send_item(3'($urandom_range(5, 7)), $urandom_range(0, 1023), $urandom_range(0, 1),
                  $urandom_range(0, 1));
    endtask

    // one fit and a batch of scored rows under one configuration
    task automatic session(int unsigned nv, int unsigned alpha_q8, int unsigned n_rows,
                           int unsigned n_evals);
        int unsigned eff;
        int unsigned len;
        setup(nv, alpha_q8);
        eff = (nv > MAX_VARS) ? MAX_VARS : nv;
        send_item(FN_BEGIN_FIT, $urandom_range(0, 1023), $urandom_range(0, 1),
                  $urandom_range(0, 1));
        for (int r = 0; r < n_rows; r++) begin
            for (int k = $urandom_range(0, 4); k > 0; k--) begin
                if (eff == 0 || $urandom_range(0, 15) == 0)
                    send_item(FN_FIT_ONE, $urandom_range(eff, 1023), 0, 0);
                else
                    send_item(FN_FIT_ONE, $urandom_range(0, eff - 1), $urandom_range(0, 1), 0);
            end
            if ($urandom_range(0, 15) == 0) noise();
            if ($urandom_range(0, 9) != 0) send_item(FN_ROW_END, $urandom_range(0, 1023), 0, 0);
        end
        send_item(FN_FINISH_FIT, $urandom_range(0, 1023), 0, 0);
        for (int j = 0; j < n_evals; j++) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(1, eff + 3);
                1: len = (eff > 1) ? eff - 1 : eff + 1;
                default: len = (eff == 0) ? 1 : eff;
            endcase
            eval_row(len);
            if ($urandom_range(0, 19) == 0) noise();
        end
    endtask

    initial begin
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_tuser = FN_BEGIN_FIT;
        cfg_we = 1'b0;
        cfg_index = REG_NUM_VARS;
        cfg_data = '0;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        drain();

        // eval before any fit, unused codes
        eval_row(1);
        eval_row(2);
        noise();
        send_item(3'd5, 1023, 1, 1);
        send_item(3'd7, 0, 0, 0);

        // full width model with zero alpha and no rows: zero denominator
        setup(2047, 0);
        send_item(FN_BEGIN_FIT, 0, 0, 0);
        send_item(FN_FIT_ONE, 0, 0, 0);
        send_item(FN_FIT_ONE, 0, 0, 0);
        send_item(FN_FIT_ONE, 1023, 1, 1);
        send_item(FN_FINISH_FIT, 0, 0, 0);
        // one row and counts above rows: p1 of one, logs of zero elsewhere
        send_item(FN_ROW_END, 0, 0, 0);
        send_item(FN_FINISH_FIT, 0, 0, 0);
        no_idle = 1;
        eval_row(1024);
        // position counter saturation on an over-long row
        eval_row(2050);
        no_idle = 0;
        // begin_fit in the middle of a scored row
        send_item(FN_EVAL_BIT, 0, 1, 0);
        send_item(FN_BEGIN_FIT, 0, 0, 0);
        send_item(FN_EVAL_BIT, 0, 0, 1);

        // bad index, largest alpha
        setup(3, 65535);
        send_item(FN_BEGIN_FIT, 0, 0, 0);
        send_item(FN_FIT_ONE, 3, 0, 0);
        send_item(FN_FIT_ONE, 1023, 0, 0);
        send_item(FN_FIT_ONE, 2, 0, 0);
        send_item(FN_ROW_END, 0, 0, 0);
        send_item(FN_FINISH_FIT, 0, 0, 0);
        eval_row(3);
        eval_row(4);

        // no variables at all
        session(0, 128, 2, 2);

        // receiver holds off while items keep coming
        setup(2, 256);
        send_item(FN_BEGIN_FIT, 0, 0, 0);
        send_item(FN_FIT_ONE, 1, 0, 0);
        send_item(FN_ROW_END, 0, 0, 0);
        send_item(FN_FINISH_FIT, 0, 0, 0);
        hold_len = 400;
        for (int j = 0; j < 20; j++) eval_row(2);

        session(1, 0, 4, 6);
        session(1024, 1, 2, 1);
        while (items_sent < 1500 + 3200) begin
            no_idle = ($urandom_range(0, 5) == 0);
            session($urandom_range(1, 24), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                    : $urandom_range(0, 1024), $urandom_range(1, 12), $urandom_range(2, 8));
        end
        no_idle = 0;
        drain();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("bernoulli_loglik_model_top regression: pass");
        else
            $display("bernoulli_loglik_model_top regression: fail");
        $finish;
    end

    initial begin
        int unsigned gap;
        int unsigned target;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_tready = 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_len = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            target = out_beats + 1;
            while (out_beats < target && hold_len == 0) @(negedge aclk);
        end
    end

    initial begin
        #200_000_000;
        $display("bernoulli_loglik_model_top regression: fail");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/blm_pkg.sv
rtl/core/blm_log2.sv
rtl/core/blm_ctrl.sv
rtl/core/blm_dp.sv
rtl/core/bernoulli_loglik_model_top.sv
tb/testbench.sv
